### sv/msq_pkg.sv
// Shared constants and triangle tables for the marching-squares cell triangulator.
package msq_pkg;

    localparam int NUM_CORNERS = 4;
    localparam int NUM_POINTS  = 8;
    localparam int MAX_VERTS   = 12;

    typedef logic [3:0] t_case;
    typedef logic [2:0] t_vcode;
    typedef logic [3:0] t_vidx;

    // number of vertices emitted for each case
    function automatic t_vidx f_count(input t_case c);
        t_vidx n;
        case (c)
            4'd0:    n = 4'd0;
            4'd1:    n = 4'd3;
            4'd2:    n = 4'd3;
            4'd3:    n = 4'd6;
            4'd4:    n = 4'd3;
            4'd5:    n = 4'd6;
            4'd6:    n = 4'd6;
            4'd7:    n = 4'd9;
            4'd8:    n = 4'd3;
            4'd9:    n = 4'd6;
            4'd10:   n = 4'd12;
            4'd11:   n = 4'd9;
            4'd12:   n = 4'd6;
            4'd13:   n = 4'd9;
            4'd14:   n = 4'd9;
            default: n = 4'd6;
        endcase
        return n;
    endfunction

    // point code of vertex k of a case: 0..3 corners, 4..7 crossings on edges 0..3
    function automatic t_vcode f_vert(input t_case c, input t_vidx k);
        logic [0:MAX_VERTS-1][2:0] l;
        t_vcode                    v;
        case (c)
            4'd1:    l = {3'd0, 3'd4, 3'd7, 27'd0};
            4'd2:    l = {3'd4, 3'd1, 3'd5, 27'd0};
            4'd3:    l = {3'd0, 3'd1, 3'd7, 3'd1, 3'd5, 3'd7, 18'd0};
            4'd4:    l = {3'd5, 3'd2, 3'd6, 27'd0};
            4'd5:    l = {3'd0, 3'd4, 3'd7, 3'd2, 3'd6, 3'd5, 18'd0};
            4'd6:    l = {3'd4, 3'd1, 3'd6, 3'd1, 3'd2, 3'd6, 18'd0};
            4'd7:    l = {3'd0, 3'd1, 3'd7, 3'd7, 3'd1, 3'd6, 3'd1, 3'd2, 3'd6, 9'd0};
            4'd8:    l = {3'd7, 3'd6, 3'd3, 27'd0};
            4'd9:    l = {3'd0, 3'd4, 3'd6, 3'd0, 3'd6, 3'd3, 18'd0};
            4'd10:   l = {3'd3, 3'd7, 3'd6, 3'd6, 3'd7, 3'd4,
                          3'd6, 3'd4, 3'd5, 3'd1, 3'd5, 3'd4};
            4'd11:   l = {3'd0, 3'd6, 3'd3, 3'd0, 3'd5, 3'd6, 3'd0, 3'd1, 3'd5, 9'd0};
            4'd12:   l = {3'd7, 3'd5, 3'd3, 3'd5, 3'd2, 3'd3, 18'd0};
            4'd13:   l = {3'd3, 3'd0, 3'd4, 3'd3, 3'd4, 3'd5, 3'd3, 3'd5, 3'd2, 9'd0};
            4'd14:   l = {3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd4, 3'd2, 3'd4, 3'd1, 9'd0};
            4'd15:   l = {3'd0, 3'd1, 3'd3, 3'd1, 3'd2, 3'd3, 18'd0};
            default: l = '0;
        endcase
        if (k < 4'(MAX_VERTS)) begin
            v = l[k];
        end else begin
            v = 3'd0;
        end
        return v;
    endfunction

endpackage

### sv/msq_cell_if.sv
// Handshake channel carrying one grid cell item.
interface msq_cell_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] corner0_value;
    logic signed [VALUE_WIDTH-1:0] corner1_value;
    logic signed [VALUE_WIDTH-1:0] corner2_value;
    logic signed [VALUE_WIDTH-1:0] corner3_value;
    logic signed [VALUE_WIDTH-1:0] corner0_x;
    logic signed [VALUE_WIDTH-1:0] corner0_y;
    logic signed [VALUE_WIDTH-1:0] corner1_x;
    logic signed [VALUE_WIDTH-1:0] corner1_y;
    logic signed [VALUE_WIDTH-1:0] corner2_x;
    logic signed [VALUE_WIDTH-1:0] corner2_y;
    logic signed [VALUE_WIDTH-1:0] corner3_x;
    logic signed [VALUE_WIDTH-1:0] corner3_y;

    modport source (
        output valid, corner0_value, corner1_value, corner2_value, corner3_value,
               corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y,
        input  ready
    );
    modport sink (
        input  valid, corner0_value, corner1_value, corner2_value, corner3_value,
               corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y,
        output ready
    );
endinterface

### sv/msq_vtx_if.sv
// Handshake channel carrying one triangle vertex item.
interface msq_vtx_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] vertex_x;
    logic signed [VALUE_WIDTH-1:0] vertex_y;
    logic                          last_vertex;

    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

### sv/marching_squares_cell_triangulator_top.sv
// Top level of the marching-squares cell triangulator pipeline.
//
//   channel  | dir | handshake     | carries
//   i_cell   | in  | valid/ready   | four corner values and positions
//   o_vtx    | out | valid/ready   | vertex x, y and last-vertex flag
//   i_cfg_*  | in  | write enable  | iso level
//
// A cell enters every cycle while the pipeline is not stalled. The alpha divider
// produces one quotient bit per stage. The emitter sends one vertex per cycle while
// o_vtx is ready, up to 12 per cell, and holds the pipeline until a cell's last is taken.
// Reset is synchronous; it clears valid bits and sets the iso level to zero.
// An output stall freezes the whole pipeline; nothing is dropped or repeated.
module marching_squares_cell_triangulator_top import msq_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic signed [VALUE_WIDTH-1:0] i_cfg_wdata,
    msq_cell_if.sink                      i_cell,
    msq_vtx_if.source                     o_vtx
);
    localparam int VW   = VALUE_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int ALAT = F + 2;
    localparam logic [VW-1:0] VSIGN = VW'(1) << (VW - 1);
    localparam logic [2*F:0]  RHALF = (2*F+1)'(1) << (F - 1);

    typedef struct packed {
        t_case                          idx;
        logic [3:0][VW-1:0]             px;
        logic [3:0][VW-1:0]             py;
        logic [3:0][VW-1:0]             mx;
        logic [3:0][VW-1:0]             my;
        logic [3:0]                     dx;
        logic [3:0]                     dy;
    } t_cell;

    logic              en, take;
    logic [VW-1:0]     r_iso;

    // iso level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
        end else if (i_cfg_we) begin
            r_iso <= i_cfg_wdata;
        end
    end

    // stage A: inside bits, corner distances, edge position spans
    logic [3:0][VW-1:0] cv, ckey, cmag;
    logic [VW-1:0]      ikey;
    t_cell              n_a;

    assign cv[0] = i_cell.corner0_value;
    assign cv[1] = i_cell.corner1_value;
    assign cv[2] = i_cell.corner2_value;
    assign cv[3] = i_cell.corner3_value;
    assign ikey  = r_iso ^ VSIGN;

    always_comb begin
        logic [VW-1:0] ka, kb;
        n_a.px[0] = i_cell.corner0_x;
        n_a.py[0] = i_cell.corner0_y;
        n_a.px[1] = i_cell.corner1_x;
        n_a.py[1] = i_cell.corner1_y;
        n_a.px[2] = i_cell.corner2_x;
        n_a.py[2] = i_cell.corner2_y;
        n_a.px[3] = i_cell.corner3_x;
        n_a.py[3] = i_cell.corner3_y;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            ckey[k]    = cv[k] ^ VSIGN;
            n_a.idx[k] = ckey[k] <= ikey;
            cmag[k]    = (ckey[k] >= ikey) ? ckey[k] - ikey : ikey - ckey[k];
        end
        for (int k = 0; k < NUM_CORNERS; k++) begin
            ka        = n_a.px[k] ^ VSIGN;
            kb        = n_a.px[(k + 1) % NUM_CORNERS] ^ VSIGN;
            n_a.dx[k] = kb >= ka;
            n_a.mx[k] = n_a.dx[k] ? kb - ka : ka - kb;
            ka        = n_a.py[k] ^ VSIGN;
            kb        = n_a.py[(k + 1) % NUM_CORNERS] ^ VSIGN;
            n_a.dy[k] = kb >= ka;
            n_a.my[k] = n_a.dy[k] ? kb - ka : ka - kb;
        end
    end

    logic               r_va;
    t_cell              r_a;
    logic [3:0][VW-1:0] r_cmag;

    assign i_cell.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= n_a;
            r_cmag <= cmag;
        end
    end

    // alpha lanes, one per edge
    logic [3:0][F-1:0] alpha;

    for (genvar e = 0; e < 4; e++) begin : g_lane
        msq_alpha #(.VALUE_WIDTH(VW), .FRAC_BITS(F)) u_alpha (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_mag_a (r_cmag[e]),
            .i_mag_b (r_cmag[(e + 1) % 4]),
            .o_alpha (alpha[e])
        );
    end

    // cell data rides alongside the alpha lanes
    t_cell            r_dl [0:ALAT-1];
    logic [ALAT-1:0]  r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (en) begin
            r_dv <= {r_dv[ALAT-2:0], r_va};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0] <= r_a;
            for (int j = 1; j < ALAT; j++) begin
                r_dl[j] <= r_dl[j-1];
            end
        end
    end

    // stage M: partial products of span times alpha
    t_cell                  c_m;
    logic [7:0][VW-1:0]     n_hp;
    logic [7:0][2*F-1:0]    n_lp;
    logic                   r_mv;
    t_cell                  r_mc;
    logic [7:0][VW-1:0]     r_hp;
    logic [7:0][2*F-1:0]    r_lp;

    assign c_m = r_dl[ALAT-1];

    always_comb begin
        logic [VW-1:0] mag;
        for (int j = 0; j < 8; j++) begin
            mag     = (j < 4) ? c_m.mx[j % 4] : c_m.my[j % 4];
            n_hp[j] = VW'(mag[VW-1:F]) * VW'(alpha[j % 4]);
            n_lp[j] = (2*F)'(mag[F-1:0]) * (2*F)'(alpha[j % 4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= r_dv[ALAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mc <= c_m;
            r_hp <= n_hp;
            r_lp <= n_lp;
        end
    end

    // stage F: round, apply offset from each edge's first corner
    logic [7:0][VW-1:0]                      n_pt_x, n_pt_y;
    logic                                    r_fv;
    t_case                                   r_fidx;
    logic [NUM_POINTS-1:0][VW-1:0]           r_fx, r_fy;

    always_comb begin
        logic [VW-1:0] t, ka, r;
        logic          dir;
        for (int k = 0; k < 4; k++) begin
            n_pt_x[k] = r_mc.px[k];
            n_pt_y[k] = r_mc.py[k];
        end
        for (int j = 0; j < 8; j++) begin
            t   = r_hp[j] + VW'(({1'b0, r_lp[j]} + RHALF) >> F);
            ka  = ((j < 4) ? r_mc.px[j % 4] : r_mc.py[j % 4]) ^ VSIGN;
            dir = (j < 4) ? r_mc.dx[j % 4] : r_mc.dy[j % 4];
            r   = dir ? ka + t : ka - t;
            if (j < 4) begin
                n_pt_x[4 + j % 4] = r ^ VSIGN;
            end else begin
                n_pt_y[4 + j % 4] = r ^ VSIGN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en) begin
            r_fv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fidx <= r_mc.idx;
            r_fx   <= n_pt_x;
            r_fy   <= n_pt_y;
        end
    end

    // pipeline moves whenever the last stage is empty or being taken
    assign en = !r_fv || take;

    msq_emit #(.VALUE_WIDTH(VW)) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_fv),
        .i_idx   (r_fidx),
        .i_pts_x (r_fx),
        .i_pts_y (r_fy),
        .o_take  (take),
        .o_vtx   (o_vtx)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_fv) |=> (r_fv && $stable(r_fidx)))
        else $error("last stage changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fv && !take) |-> !i_cell.ready)
        else $error("input taken while pipeline stalled");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_fv == $past(r_mv)))
        else $error("valid bit lost between stages");

endmodule

### sv/msq_alpha.sv
// Pipelined interpolation weight unit: alpha = |phi_a| / (|phi_a| + |phi_b|), one bit per stage.
module msq_alpha #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [VALUE_WIDTH-1:0] i_mag_a,
    input  logic [VALUE_WIDTH-1:0] i_mag_b,
    output logic [FRAC_BITS-1:0]   o_alpha
);
    localparam int MW   = VALUE_WIDTH;
    localparam int LIMB = 63 - FRAC_BITS;
    localparam int SMAX = (MW > LIMB) ? (MW - LIMB) : 0;
    localparam int SW   = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
    localparam logic [63:0] LIM = 64'd1 << LIMB;
    localparam logic [FRAC_BITS:0] ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] A_MIN =
        (FRAC_BITS+1)'(((64'd1 << FRAC_BITS) + 64'd99999) / 64'd100000);
    localparam logic [FRAC_BITS:0] A_MAX = ONE - A_MIN;
    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    logic [SW-1:0]  sh;
    logic [MW-1:0]  na, nb;
    logic [MW:0]    n_sum;

    // joint halving of huge magnitudes
    always_comb begin
        sh = '0;
        for (int s = SMAX; s >= 0; s--) begin
            if ((64'(i_mag_a >> s) <= LIM) && (64'(i_mag_b >> s) <= LIM)) begin
                sh = SW'(s);
            end
        end
        na    = i_mag_a >> sh;
        nb    = i_mag_b >> sh;
        n_sum = {1'b0, na} + {1'b0, nb};
    end

    logic [MW-1:0]    r_na;
    logic [MW:0]      r_sum0;
    logic [MW:0]      r_sum [0:FRAC_BITS];
    logic [MW:0]      r_rem [0:FRAC_BITS];
    logic [FRAC_BITS:0] r_q [0:FRAC_BITS];
    logic [MW:0]      d_rem [0:FRAC_BITS];
    logic [FRAC_BITS:0] d_q [0:FRAC_BITS];

    // restoring division steps, quotient MSB first
    always_comb begin
        logic [MW+1:0] trial;
        logic [MW:0]   sv;
        logic          ge;
        for (int j = 0; j <= FRAC_BITS; j++) begin
            if (j == 0) begin
                trial = (MW+2)'(r_na);
                sv    = r_sum0;
            end else begin
                trial = {r_rem[j-1], 1'b0};
                sv    = r_sum[j-1];
            end
            ge       = trial >= {1'b0, sv};
            d_rem[j] = ge ? (MW+1)'(trial - {1'b0, sv}) : (MW+1)'(trial);
            if (j == 0) begin
                d_q[j] = (FRAC_BITS+1)'(ge);
            end else begin
                d_q[j] = {r_q[j-1][FRAC_BITS-1:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_na   <= na;
            r_sum0 <= n_sum;
            for (int j = 0; j <= FRAC_BITS; j++) begin
                r_sum[j] <= (j == 0) ? r_sum0 : r_sum[j-1];
                r_rem[j] <= d_rem[j];
                r_q[j]   <= d_q[j];
            end
        end
    end

    // zero-sum fallback and clamp
    always_comb begin
        if (r_sum[FRAC_BITS] == '0) begin
            o_alpha = HALF;
        end else if (r_q[FRAC_BITS] < A_MIN) begin
            o_alpha = FRAC_BITS'(A_MIN);
        end else if (r_q[FRAC_BITS] > A_MAX) begin
            o_alpha = FRAC_BITS'(A_MAX);
        end else begin
            o_alpha = r_q[FRAC_BITS][FRAC_BITS-1:0];
        end
    end

endmodule

### sv/msq_emit.sv
// Vertex emitter: holds one triangulated cell and sends its vertex list one item per cycle while o_vtx is ready.
module msq_emit import msq_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  t_case                                  i_idx,
    input  logic [NUM_POINTS-1:0][VALUE_WIDTH-1:0] i_pts_x,
    input  logic [NUM_POINTS-1:0][VALUE_WIDTH-1:0] i_pts_y,
    output logic                                   o_take,
    msq_vtx_if.source                              o_vtx
);
    logic                                   r_busy;
    t_vidx                                  r_k, r_n;
    t_case                                  r_idx;
    logic [NUM_POINTS-1:0][VALUE_WIDTH-1:0] r_x, r_y;
    logic                                   fire, last;
    t_vcode                                 code;

    assign fire   = o_vtx.valid && o_vtx.ready;
    assign last   = (r_k == r_n - 4'd1);
    assign o_take = !r_busy || (fire && last);
    assign code   = f_vert(r_idx, r_k);

    assign o_vtx.valid       = r_busy;
    assign o_vtx.vertex_x    = r_x[code];
    assign o_vtx.vertex_y    = r_y[code];
    assign o_vtx.last_vertex = last;

    // load a new cell or step through the current list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_n    <= '0;
            r_idx  <= '0;
        end else if (o_take) begin
            r_busy <= i_vld && (f_count(i_idx) != 4'd0);
            r_k    <= '0;
            r_n    <= f_count(i_idx);
            r_idx  <= i_idx;
        end else if (fire) begin
            r_k <= r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_x <= i_pts_x;
            r_y <= i_pts_y;
        end
    end

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k < r_n)) else $error("vertex index past count");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !last) |=> (r_busy && r_k == $past(r_k) + 4'd1))
        else $error("vertex run broken");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (f_count(r_idx) == r_n && r_n != 4'd0))
        else $error("count does not match case");

endmodule
